### src/cpms_pkg.sv
// cpms_pkg: shared types, codes and conversion for the cuff pressure sequencer
// used by cuff_pressure_measurement_sequencer and cpms_checker; no dependencies

package cpms_pkg;

  // control states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_INFLATE = 6'b000010,
    ST_SETTLE  = 6'b000100,
    ST_MEASURE = 6'b001000,
    ST_DEFLATE = 6'b010000,
    ST_REPORT  = 6'b100000
  } state_t;

  // phase codes as shown on the result stream
  localparam logic [2:0] PHASE_IDLE    = 3'd0;
  localparam logic [2:0] PHASE_INFLATE = 3'd1;
  localparam logic [2:0] PHASE_SETTLE  = 3'd2;
  localparam logic [2:0] PHASE_MEASURE = 3'd3;
  localparam logic [2:0] PHASE_DEFLATE = 3'd4;
  localparam logic [2:0] PHASE_REPORT  = 3'd5;

  // input action codes
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_PRESS  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MAX_PRESSURE     = 3'd0;
  localparam logic [2:0] CFG_MIN_PRESSURE     = 3'd1;
  localparam logic [2:0] CFG_RISE_LIMIT       = 3'd2;
  localparam logic [2:0] CFG_QUIET_TICKS      = 3'd3;
  localparam logic [2:0] CFG_VALVE_OPEN_TICKS = 3'd4;
  localparam logic [2:0] CFG_VALVE_PERIOD     = 3'd5;
  localparam logic [2:0] CFG_SAMPLE_PERIOD    = 3'd6;

  // raw to mmHg: 0.56 and 14.09 in Q16, round half up
  localparam logic [25:0] MMHG_SCALE  = 26'd36700;
  localparam logic [25:0] MMHG_OFFSET = 26'd923402;
  localparam logic [25:0] MMHG_HALF   = 26'd32768;
  localparam logic [9:0]  MMHG_MAX    = 10'd999;

  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 32;

  function automatic logic [9:0] to_mmhg(input logic [9:0] raw);
    logic [25:0] v;
    logic [25:0] d;
    logic [9:0]  r;
    v = 26'(raw) * MMHG_SCALE + MMHG_HALF;
    d = v - MMHG_OFFSET;
    r = d[25:16];
    if (v < MMHG_OFFSET) begin
      return 10'd0;
    end
    if (r > MMHG_MAX) begin
      return MMHG_MAX;
    end
    return r;
  endfunction

  function automatic logic [2:0] phase_code(input state_t st);
    unique case (st)
      ST_IDLE:    return PHASE_IDLE;
      ST_INFLATE: return PHASE_INFLATE;
      ST_SETTLE:  return PHASE_SETTLE;
      ST_MEASURE: return PHASE_MEASURE;
      ST_DEFLATE: return PHASE_DEFLATE;
      ST_REPORT:  return PHASE_REPORT;
      default:    return PHASE_IDLE;
    endcase
  endfunction

endpackage

### src/cuff_pressure_measurement_sequencer.sv
// cuff_pressure_measurement_sequencer: cuff phase sequencer with pulse capture
// depends on cpms_pkg

// One result per input transaction. An item is taken into an input register,
// the state update runs from that register once the output register is free
// or being read, and its result lands in the output register. The
// single registered state update sets the rate: one item per clock while the
// result side keeps taking results. Configuration writes are always accepted.
module cuff_pressure_measurement_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // sample[9:0], zeros[15:10]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // phase[2:0], pump_on[3], valve_open[4],
                                 // sample_request[5], systolic_mmhg[15:6],
                                 // diastolic_mmhg[25:16], zeros[31:26]
  output logic        m_tuser,   // result_valid[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [9:0]  max_pressure;
  logic [9:0]  min_pressure;
  logic [9:0]  rise_limit;
  logic [15:0] quiet_ticks;
  logic [15:0] valve_open_ticks;
  logic [15:0] valve_period;
  logic [7:0]  sample_period;

  // input register
  logic        in_valid;
  logic [1:0]  in_action;
  logic [9:0]  in_sample;

  // sequencer state
  cpms_pkg::state_t st, st_next;
  logic        entered, entered_next;
  logic [9:0]  latest, latest_next;
  logic [9:0]  prior, prior_next;
  logic        sys_found, sys_found_next;
  logic [9:0]  sys_raw, sys_raw_next;
  logic [9:0]  dia_raw, dia_raw_next;
  logic [15:0] quiet_cnt, quiet_cnt_next;
  logic [15:0] valve_cnt, valve_cnt_next;
  logic [7:0]  sample_cnt, sample_cnt_next;

  logic        advance;
  logic        pulse;
  logic        req;
  logic        res;
  logic        pump;
  logic        valve;
  logic [15:0] valve_inc;
  logic [7:0]  sample_inc;
  logic [9:0]  sys_mm;
  logic [9:0]  dia_mm;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pressure     <= 10'd500;
      min_pressure     <= 10'd50;
      rise_limit       <= 10'd400;
      quiet_ticks      <= 16'd2000;
      valve_open_ticks <= 16'd7;
      valve_period     <= 16'd500;
      sample_period    <= 8'd15;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cpms_pkg::CFG_MAX_PRESSURE:     max_pressure     <= cfg_data[9:0];
        cpms_pkg::CFG_MIN_PRESSURE:     min_pressure     <= cfg_data[9:0];
        cpms_pkg::CFG_RISE_LIMIT:       rise_limit       <= cfg_data[9:0];
        cpms_pkg::CFG_QUIET_TICKS:      quiet_ticks      <= cfg_data;
        cpms_pkg::CFG_VALVE_OPEN_TICKS: valve_open_ticks <= cfg_data;
        cpms_pkg::CFG_VALVE_PERIOD:     valve_period     <= cfg_data;
        cpms_pkg::CFG_SAMPLE_PERIOD:    sample_period    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_sample <= s_tdata[9:0];
    end
  end

  always_comb begin
    st_next         = st;
    entered_next    = entered;
    latest_next     = latest;
    prior_next      = prior;
    sys_found_next  = sys_found;
    sys_raw_next    = sys_raw;
    dia_raw_next    = dia_raw;
    quiet_cnt_next  = quiet_cnt;
    valve_cnt_next  = valve_cnt;
    sample_cnt_next = sample_cnt;
    req             = 1'b0;
    res             = 1'b0;
    pulse           = (prior < latest) && ((latest - prior) < rise_limit);
    valve_inc       = 16'd0;
    sample_inc      = 8'd0;

    unique case (in_action)
      cpms_pkg::ACT_SAMPLE: latest_next = in_sample;
      cpms_pkg::ACT_PRESS: begin
        if (st == cpms_pkg::ST_IDLE) begin
          st_next = cpms_pkg::ST_INFLATE;
        end else begin
          st_next      = cpms_pkg::ST_IDLE;
          entered_next = 1'b0;
        end
      end
      cpms_pkg::ACT_TICK: begin
        unique case (st)
          cpms_pkg::ST_IDLE: begin
            if (!entered) begin
              entered_next   = 1'b1;
              sys_found_next = 1'b0;
            end
          end
          cpms_pkg::ST_INFLATE: begin
            if (latest >= max_pressure) st_next = cpms_pkg::ST_SETTLE;
          end
          cpms_pkg::ST_SETTLE: begin
            if (latest == prior) st_next = cpms_pkg::ST_MEASURE;
          end
          cpms_pkg::ST_MEASURE: begin
            if (!sys_found) begin
              if (pulse) begin
                sys_raw_next   = prior;
                sys_found_next = 1'b1;
                quiet_cnt_next = 16'd0;
              end
            end else if (pulse) begin
              dia_raw_next   = prior;
              quiet_cnt_next = 16'd0;
            end else if (quiet_cnt >= quiet_ticks) begin
              st_next = cpms_pkg::ST_DEFLATE;
            end
          end
          cpms_pkg::ST_DEFLATE: begin
            if (latest <= min_pressure) st_next = cpms_pkg::ST_REPORT;
          end
          cpms_pkg::ST_REPORT: begin
            res            = 1'b1;
            entered_next   = 1'b0;
            sys_found_next = 1'b0;
            st_next        = cpms_pkg::ST_IDLE;
          end
          default: st_next = cpms_pkg::ST_IDLE;
        endcase

        if (quiet_cnt_next != 16'hFFFF) quiet_cnt_next = quiet_cnt_next + 16'd1;
        valve_inc = (valve_cnt == 16'hFFFF) ? valve_cnt : valve_cnt + 16'd1;
        if (st_next == cpms_pkg::ST_MEASURE && valve_inc >= valve_period) begin
          valve_cnt_next = 16'd0;
        end else begin
          valve_cnt_next = valve_inc;
        end
        sample_inc = sample_cnt + 8'd1;
        if (sample_inc >= sample_period) begin
          sample_cnt_next = 8'd0;
          req             = 1'b1;
          prior_next      = latest;
        end else begin
          sample_cnt_next = sample_inc;
        end
      end
      default: ;
    endcase

    pump  = 1'b0;
    valve = 1'b0;
    unique case (st_next)
      cpms_pkg::ST_IDLE:    valve = 1'b1;
      cpms_pkg::ST_INFLATE: pump  = 1'b1;
      cpms_pkg::ST_SETTLE:  ;
      cpms_pkg::ST_MEASURE: valve = (valve_cnt_next == 16'd0) ||
                                    (valve_cnt_next < valve_open_ticks);
      cpms_pkg::ST_DEFLATE: valve = 1'b1;
      cpms_pkg::ST_REPORT:  valve = 1'b1;
      default: ;
    endcase

    sys_mm = res ? cpms_pkg::to_mmhg(sys_raw) : 10'd0;
    dia_mm = res ? cpms_pkg::to_mmhg(dia_raw) : 10'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= cpms_pkg::ST_IDLE;
      entered    <= 1'b0;
      latest     <= 10'd0;
      prior      <= 10'd0;
      sys_found  <= 1'b0;
      sys_raw    <= 10'd0;
      dia_raw    <= 10'd0;
      quiet_cnt  <= 16'd0;
      valve_cnt  <= 16'd0;
      sample_cnt <= 8'd0;
    end else if (advance) begin
      st         <= st_next;
      entered    <= entered_next;
      latest     <= latest_next;
      prior      <= prior_next;
      sys_found  <= sys_found_next;
      sys_raw    <= sys_raw_next;
      dia_raw    <= dia_raw_next;
      quiet_cnt  <= quiet_cnt_next;
      valve_cnt  <= valve_cnt_next;
      sample_cnt <= sample_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'd0, dia_mm, sys_mm, req, valve, pump,
                  cpms_pkg::phase_code(st_next)};
      m_tuser <= res;
    end
  end

endmodule

### src/cpms_checker.sv
// cpms_checker: port-level assertions for the cuff pressure sequencer
// depends on cpms_pkg; bound to cuff_pressure_measurement_sequencer

module cpms_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // a reported measurement always returns the cuff to idle with the valve open
  a_report_to_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (m_tdata[2:0] == cpms_pkg::PHASE_IDLE) && m_tdata[4])
    else $error("report transaction not in idle with valve open");

  // the pump runs only while inflating and never with the valve open
  a_pump_phase: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |->
      (m_tdata[2:0] == cpms_pkg::PHASE_INFLATE) && !m_tdata[4])
    else $error("pump on outside inflate");

  // pressure fields are zero unless a measurement is reported
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[25:6] == 20'd0))
    else $error("pressure fields set without a result");

  // reported pressures stay in range
  a_mmhg_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (m_tdata[15:6] <= cpms_pkg::MMHG_MAX) && (m_tdata[25:16] <= cpms_pkg::MMHG_MAX))
    else $error("pressure out of range");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind cuff_pressure_measurement_sequencer cpms_checker u_cpms_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### tb/cuff_pressure_measurement_sequencer_tb.sv
`timescale 1ns / 100ps
// cuff_pressure_measurement_sequencer_tb: self-checking bench for the cuff sequencer,
// predicts every result transaction from its own copy of the phase state and registers
// depends on cpms_pkg and cuff_pressure_measurement_sequencer

module cuff_pressure_measurement_sequencer_tb;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int unsigned ITEM_TARGET = 400;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [31:0] Q16_SCALE = 32'd36700;
  localparam logic [31:0] Q16_OFFSET = 32'd923402;
  localparam logic [31:0] Q16_HALF = 32'd32768;
  localparam logic [31:0] MMHG_CEIL = 32'd999;
  localparam logic [15:0] COUNT_SAT = 16'hFFFF;

  typedef struct packed {
    logic [1:0] act;
    logic [9:0] smp;
  } cuff_item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       pump;
    logic       valve;
    logic       req;
    logic       valid;
    logic [9:0] sys;
    logic [9:0] dia;
  } cuff_obs_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // register mirror
  logic [9:0]  lim_max = 10'd500;
  logic [9:0]  lim_min = 10'd50;
  logic [9:0]  lim_rise = 10'd400;
  logic [15:0] lim_quiet = 16'd2000;
  logic [15:0] lim_vopen = 16'd7;
  logic [15:0] lim_vper = 16'd500;
  logic [7:0]  lim_smp = 8'd15;

  // sequencer state mirror
  logic [2:0]  phase_q = cpms_pkg::PHASE_IDLE;
  logic        armed = 1'b0;
  logic [9:0]  latest_p = '0;
  logic [9:0]  prior_p = '0;
  logic        sys_seen = 1'b0;
  logic [9:0]  sys_raw = '0;
  logic [9:0]  dia_raw = '0;
  logic [15:0] quiet_cnt = '0;
  logic [15:0] valve_cnt = '0;
  logic [7:0]  smp_cnt = '0;

  cuff_item_t  pending_events[$];
  cuff_obs_t   awaited_readings[$];
  cuff_item_t  cur_item;
  cuff_obs_t   got, want;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b1;
  int unsigned n_queued = 0;
  int unsigned n_sent = 0;
  int unsigned n_results = 0;
  int unsigned n_reports = 0;
  int unsigned n_err = 0;
  int unsigned n_settings = 0;
  int unsigned cycles = 0;

  cuff_pressure_measurement_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [9:0] raw_to_mmhg(input logic [9:0] raw);
    logic [31:0] acc;
    acc = 32'(raw) * Q16_SCALE + Q16_HALF;
    if (acc < Q16_OFFSET) begin
      return 10'd0;
    end
    acc = (acc - Q16_OFFSET) >> 16;
    return (acc > MMHG_CEIL) ? MMHG_CEIL[9:0] : acc[9:0];
  endfunction

  function automatic cuff_obs_t advance_cuff(input cuff_item_t it);
    cuff_obs_t r;
    logic      pulse;
    r = '0;
    pulse = (prior_p < latest_p) && ((latest_p - prior_p) < lim_rise);
    case (it.act)
      cpms_pkg::ACT_SAMPLE: latest_p = it.smp;
      cpms_pkg::ACT_PRESS: begin
        if (phase_q == cpms_pkg::PHASE_IDLE) begin
          phase_q = cpms_pkg::PHASE_INFLATE;
        end else begin
          phase_q = cpms_pkg::PHASE_IDLE;
          armed = 1'b0;
        end
      end
      cpms_pkg::ACT_TICK: begin
        case (phase_q)
          cpms_pkg::PHASE_IDLE: begin
            if (!armed) begin
              armed = 1'b1;
              sys_seen = 1'b0;
            end
          end
          cpms_pkg::PHASE_INFLATE: if (latest_p >= lim_max) phase_q = cpms_pkg::PHASE_SETTLE;
          cpms_pkg::PHASE_SETTLE: if (latest_p == prior_p) phase_q = cpms_pkg::PHASE_MEASURE;
          cpms_pkg::PHASE_MEASURE: begin
            if (!sys_seen) begin
              if (pulse) begin
                sys_raw = prior_p;
                sys_seen = 1'b1;
                quiet_cnt = '0;
              end
            end else if (pulse) begin
              dia_raw = prior_p;
              quiet_cnt = '0;
            end else if (quiet_cnt >= lim_quiet) begin
              phase_q = cpms_pkg::PHASE_DEFLATE;
            end
          end
          cpms_pkg::PHASE_DEFLATE: if (latest_p <= lim_min) phase_q = cpms_pkg::PHASE_REPORT;
          cpms_pkg::PHASE_REPORT: begin
            r.valid = 1'b1;
            r.sys = raw_to_mmhg(sys_raw);
            r.dia = raw_to_mmhg(dia_raw);
            armed = 1'b0;
            sys_seen = 1'b0;
            phase_q = cpms_pkg::PHASE_IDLE;
          end
          default: phase_q = cpms_pkg::PHASE_IDLE;
        endcase
        if (quiet_cnt != COUNT_SAT) quiet_cnt = quiet_cnt + 16'd1;
        if (valve_cnt != COUNT_SAT) valve_cnt = valve_cnt + 16'd1;
        if (phase_q == cpms_pkg::PHASE_MEASURE && valve_cnt >= lim_vper) valve_cnt = '0;
        smp_cnt = smp_cnt + 8'd1;
        if (smp_cnt >= lim_smp) begin
          smp_cnt = '0;
          r.req = 1'b1;
          prior_p = latest_p;
        end
      end
      default: ;
    endcase
    r.phase = phase_q;
    case (phase_q)
      cpms_pkg::PHASE_IDLE:    r.valve = 1'b1;
      cpms_pkg::PHASE_INFLATE: r.pump = 1'b1;
      cpms_pkg::PHASE_MEASURE: r.valve = (valve_cnt == 16'd0) || (valve_cnt < lim_vopen);
      cpms_pkg::PHASE_DEFLATE: r.valve = 1'b1;
      cpms_pkg::PHASE_REPORT:  r.valve = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  // mostly short idles, now and then a long one
  function automatic int unsigned draw_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned cap(input int unsigned v, input int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  task automatic push_item(input logic [1:0] act, input int unsigned smp);
    cuff_item_t it;
    it.act = act;
    it.smp = smp[9:0];
    pending_events.push_back(it);
    n_queued++;
  endtask

  task automatic push_ticks(input int unsigned n);
    repeat (n) push_item(cpms_pkg::ACT_TICK, $urandom_range(0, 1023));
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cpms_pkg::CFG_MAX_PRESSURE:     lim_max = val[9:0];
      cpms_pkg::CFG_MIN_PRESSURE:     lim_min = val[9:0];
      cpms_pkg::CFG_RISE_LIMIT:       lim_rise = val[9:0];
      cpms_pkg::CFG_QUIET_TICKS:      lim_quiet = val[15:0];
      cpms_pkg::CFG_VALVE_OPEN_TICKS: lim_vopen = val[15:0];
      cpms_pkg::CFG_VALVE_PERIOD:     lim_vper = val[15:0];
      cpms_pkg::CFG_SAMPLE_PERIOD:    lim_smp = val[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int unsigned mx, input int unsigned mn,
                           input int unsigned rise, input int unsigned quiet,
                           input int unsigned vopen, input int unsigned vper,
                           input int unsigned sper);
    write_reg(cpms_pkg::CFG_MAX_PRESSURE, mx);
    write_reg(cpms_pkg::CFG_MIN_PRESSURE, mn);
    write_reg(cpms_pkg::CFG_RISE_LIMIT, rise);
    write_reg(cpms_pkg::CFG_QUIET_TICKS, quiet);
    write_reg(cpms_pkg::CFG_VALVE_OPEN_TICKS, vopen);
    write_reg(cpms_pkg::CFG_VALVE_PERIOD, vper);
    write_reg(cpms_pkg::CFG_SAMPLE_PERIOD, sper);
    n_settings++;
  endtask

  // start, inflate, settle, pulses on a falling baseline, quiet, deflate, report
  task automatic queue_measurement();
    int unsigned top, base, step;
    push_item(cpms_pkg::ACT_TICK, $urandom_range(0, 1023));
    push_item(cpms_pkg::ACT_PRESS, $urandom_range(0, 1023));
    repeat ($urandom_range(1, 3)) begin
      push_item(cpms_pkg::ACT_SAMPLE, $urandom_range(0, lim_max));
      push_ticks(1);
    end
    top = cap(lim_max + $urandom_range(0, 20), 1023);
    push_item(cpms_pkg::ACT_SAMPLE, top);
    push_ticks(1 + cap(lim_smp + 1, 24));
    base = top;
    repeat ($urandom_range(2, 5)) begin
      step = (lim_rise > 10'd1) ? $urandom_range(1, cap(lim_rise - 1, 40)) : 1;
      push_item(cpms_pkg::ACT_SAMPLE, cap(base + step, 1023));
      push_ticks($urandom_range(1, 2));
      if (base > 30) base = base - $urandom_range(2, 30);
      push_item(cpms_pkg::ACT_SAMPLE, base);
      push_ticks(cap(lim_smp, 24));
    end
    push_ticks(cap(lim_quiet, 40) + 2);
    push_item(cpms_pkg::ACT_SAMPLE, $urandom_range(0, lim_min));
    push_ticks(3);
  endtask

  task automatic queue_noise(input int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r < 5) push_item(cpms_pkg::ACT_TICK, $urandom_range(0, 1023));
      else if (r < 8) push_item(cpms_pkg::ACT_SAMPLE, $urandom_range(0, 1023));
      else if (r < 9) push_item(cpms_pkg::ACT_PRESS, $urandom_range(0, 1023));
      else push_item(ACT_SPARE, $urandom_range(0, 1023));
    end
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || awaited_readings.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_readings.push_back(advance_cuff(cur_item));
        n_sent++;
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left = gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        cur_item = pending_events.pop_front();
        s_tdata <= {6'd0, cur_item.smp};
        s_tuser <= cur_item.act;
        s_tvalid <= 1'b1;
        gap_left = calm ? 0 : draw_idle_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.phase = m_tdata[2:0];
        got.pump = m_tdata[3];
        got.valve = m_tdata[4];
        got.req = m_tdata[5];
        got.sys = m_tdata[15:6];
        got.dia = m_tdata[25:16];
        got.valid = m_tuser;
        n_results++;
        if (got.valid) n_reports++;
        if (awaited_readings.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result transaction: tdata=%h tuser=%b",
                                    m_tdata, m_tuser);
        end else begin
          want = awaited_readings.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= 10) begin
              $display("mismatch at result %0d:", n_results);
              $display("  exp phase=%0d pump=%b valve=%b req=%b valid=%b sys=%0d dia=%0d",
                       want.phase, want.pump, want.valve, want.req, want.valid,
                       want.sys, want.dia);
              $display("  got phase=%0d pump=%b valve=%b req=%b valid=%b sys=%0d dia=%0d",
                       got.phase, got.pump, got.valve, got.req, got.valid,
                       got.sys, got.dia);
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = calm ? 0 : draw_idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycles, awaited_readings.size());
      $display("cuff_pressure_measurement_sequencer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned mark;
    int unsigned setting;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset values: unused code, extremes of the sample, start from idle, stop from inflate and settle
    push_item(cpms_pkg::ACT_TICK, 1023);
    push_item(ACT_SPARE, 10'h155);
    push_item(cpms_pkg::ACT_SAMPLE, 0);
    push_item(cpms_pkg::ACT_PRESS, 10'h2AA);
    push_item(cpms_pkg::ACT_TICK, 0);
    push_item(cpms_pkg::ACT_SAMPLE, 1023);
    push_item(ACT_SPARE, 0);
    push_item(cpms_pkg::ACT_TICK, 0);
    push_item(cpms_pkg::ACT_TICK, 1023);
    push_item(cpms_pkg::ACT_PRESS, 0);
    push_item(cpms_pkg::ACT_PRESS, 1023);
    push_item(cpms_pkg::ACT_PRESS, 0);
    push_item(cpms_pkg::ACT_TICK, 0);
    push_item(cpms_pkg::ACT_TICK, 0);
    wait_drained();

    setting = 0;
    while (n_queued < ITEM_TARGET) begin
      case (setting)
        0: configure(300, 40, 100, 6, 2, 5, 2);
        1: configure(1023, 1023, 1023, 1, 0, 1, 1);
        2: configure(0, 0, 0, 12, 65535, 65535, 3);
        3: configure(700, 100, 60, 65535, 3, 9, 255);
        default: configure($urandom_range(100, 1023), $urandom_range(0, 200),
                           $urandom_range(2, 300), $urandom_range(1, 24),
                           $urandom_range(0, 6), $urandom_range(1, 10),
                           $urandom_range(1, 5));
      endcase
      calm = ($urandom_range(0, 3) == 0);
      mark = n_queued;
      while (n_queued - mark < 70) begin
        if ($urandom_range(0, 9) < 7) queue_measurement();
        else queue_noise($urandom_range(4, 16));
      end
      wait_drained();
      setting++;
    end

    $display("%0d input transactions over %0d register settings after reset values",
             n_sent, n_settings);
    $display("%0d results checked, %0d of them finished measurements, %0d mismatches",
             n_results, n_reports, n_err);
    if (n_err == 0) begin
      $display("cuff_pressure_measurement_sequencer_tb: done, clean");
    end else begin
      $display("cuff_pressure_measurement_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule
